### sv/svpd_pkg.sv
// Shared constants, types and the sector decode for the space vector PWM duty unit.
package svpd_pkg;

  localparam int unsigned QuotW = 47;
  localparam int unsigned RemW = 32;
  localparam int unsigned SumW = 51;

  localparam logic [15:0] ModIndexReset = 16'd32768;
  localparam logic [15:0] InvSqrt3Q16 = 16'd37837;
  localparam logic [15:0] HalfDuty = 16'd32768;
  localparam logic [15:0] MaxDuty = 16'hFFFF;
  localparam logic signed [SumW-1:0] OneQ16 = 51'sd65536;

  localparam logic [2:0] SectNull = 3'd0;
  localparam logic [2:0] Sect1 = 3'd1;
  localparam logic [2:0] Sect2 = 3'd2;
  localparam logic [2:0] Sect3 = 3'd3;
  localparam logic [2:0] Sect4 = 3'd4;
  localparam logic [2:0] Sect5 = 3'd5;
  localparam logic [2:0] Sect6 = 3'd6;

  typedef struct packed {
    logic [2:0] sector;
    logic       neg1;
    logic       neg2;
  } side_t;

  typedef struct packed {
    logic [RemW-1:0]  vs;
    logic [RemW-1:0]  rem1;
    logic [RemW-1:0]  rem2;
    logic [QuotW-1:0] pq1;
    logic [QuotW-1:0] pq2;
    side_t            side;
  } div_t;

  function automatic logic [2:0] sector_of(input logic [2:0] code);
    logic [2:0] s;
    case (code)
      3'd3: s = Sect1;
      3'd2: s = Sect2;
      3'd6: s = Sect3;
      3'd4: s = Sect4;
      3'd5: s = Sect5;
      3'd1: s = Sect6;
      default: s = SectNull;
    endcase
    return s;
  endfunction

endpackage

### sv/svpd_front.sv
// Front stages: sector decode, phase selection, bus scaling and magnitudes.
module svpd_front
  import svpd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        adv,
  input  logic        in_valid,
  input  logic [15:0] in_voltage_a,
  input  logic [15:0] in_voltage_b,
  input  logic [15:0] in_voltage_c,
  input  logic [15:0] in_dc_link,
  input  logic [15:0] mod_index,
  output logic        div_valid,
  output div_t        div_data
);

  logic                valid_a_r, valid_b_r;
  logic [31:0]         prod_a_r;
  logic [2:0]          sector_a_r;
  logic signed [16:0]  s1_a_r, s2_a_r;
  logic signed [16:0]  s1_nxt, s2_nxt;
  logic signed [16:0]  va, vb, vc;
  logic [2:0]          code, sector_nxt;
  logic [47:0]         vs_prod;
  logic [15:0]         mag1, mag2;
  logic [16:0]         abs1, abs2;
  div_t                div_b_r;

  assign va = {in_voltage_a[15], in_voltage_a};
  assign vb = {in_voltage_b[15], in_voltage_b};
  assign vc = {in_voltage_c[15], in_voltage_c};
  assign code = {!in_voltage_c[15] && (|in_voltage_c),
                 !in_voltage_b[15] && (|in_voltage_b),
                 !in_voltage_a[15] && (|in_voltage_a)};
  assign sector_nxt = sector_of(code);

  always_comb begin
    case (sector_nxt)
      Sect1: begin s1_nxt = va; s2_nxt = vb; end
      Sect2: begin s1_nxt = -vc; s2_nxt = -va; end
      Sect3: begin s1_nxt = vb; s2_nxt = vc; end
      Sect4: begin s1_nxt = -va; s2_nxt = -vb; end
      Sect5: begin s1_nxt = vc; s2_nxt = va; end
      Sect6: begin s1_nxt = -vb; s2_nxt = -vc; end
      default: begin s1_nxt = va; s2_nxt = vb; end
    endcase
  end

  assign vs_prod = prod_a_r * {32'd0, InvSqrt3Q16};
  assign abs1 = s1_a_r[16] ? 17'(-s1_a_r) : 17'(s1_a_r);
  assign abs2 = s2_a_r[16] ? 17'(-s2_a_r) : 17'(s2_a_r);
  assign mag1 = abs1[15:0];
  assign mag2 = abs2[15:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_a_r <= 1'b0;
      valid_b_r <= 1'b0;
    end else if (adv) begin
      valid_a_r <= in_valid;
      valid_b_r <= valid_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_a_r <= {16'd0, mod_index} * {16'd0, in_dc_link};
      sector_a_r <= sector_nxt;
      s1_a_r <= s1_nxt;
      s2_a_r <= s2_nxt;
      div_b_r.vs <= vs_prod[47:16];
      div_b_r.rem1 <= '0;
      div_b_r.rem2 <= '0;
      div_b_r.pq1 <= {mag1, 31'd0};
      div_b_r.pq2 <= {mag2, 31'd0};
      div_b_r.side.sector <= sector_a_r;
      div_b_r.side.neg1 <= s1_a_r[16];
      div_b_r.side.neg2 <= s2_a_r[16];
    end
  end

  assign div_valid = valid_b_r;
  assign div_data = div_b_r;

endmodule

### sv/svpd_divider.sv
// Pipelined restoring divider, one quotient bit per stage, two numerators per item.
module svpd_divider
  import svpd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic adv,
  input  logic in_valid,
  input  div_t in_data,
  output logic out_valid,
  output div_t out_data
);

  logic [QuotW:0] valid_r;
  div_t           stage_r [QuotW+1];

  function automatic logic [RemW+QuotW-1:0] step(input logic [RemW-1:0] vs,
                                                 input logic [RemW-1:0] rem,
                                                 input logic [QuotW-1:0] pq);
    logic [RemW:0]   trial;
    logic [RemW-1:0] rem_n;
    logic            qbit;
    trial = {rem, pq[QuotW-1]};
    qbit = (trial >= {1'b0, vs});
    rem_n = qbit ? RemW'(trial - {1'b0, vs}) : trial[RemW-1:0];
    return {rem_n, pq[QuotW-2:0], qbit};
  endfunction

  assign valid_r[0] = in_valid;
  assign stage_r[0] = in_data;

  for (genvar i = 0; i < QuotW; i++) begin : g_step
    logic [RemW+QuotW-1:0] r1, r2;
    assign r1 = step(stage_r[i].vs, stage_r[i].rem1, stage_r[i].pq1);
    assign r2 = step(stage_r[i].vs, stage_r[i].rem2, stage_r[i].pq2);
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[i+1] <= 1'b0;
      end else if (adv) begin
        valid_r[i+1] <= valid_r[i];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        stage_r[i+1].vs <= stage_r[i].vs;
        stage_r[i+1].side <= stage_r[i].side;
        stage_r[i+1].rem1 <= r1[RemW+QuotW-1:QuotW];
        stage_r[i+1].pq1 <= r1[QuotW-1:0];
        stage_r[i+1].rem2 <= r2[RemW+QuotW-1:QuotW];
        stage_r[i+1].pq2 <= r2[QuotW-1:0];
      end
    end
  end

  assign out_valid = valid_r[QuotW];
  assign out_data = stage_r[QuotW];

endmodule

### sv/svpd_back.sv
// Back stages: signed times, per-sector duty sums and saturation.
module svpd_back
  import svpd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        adv,
  input  logic        in_valid,
  input  div_t        in_data,
  output logic        out_valid,
  output logic [15:0] out_duty_a,
  output logic [15:0] out_duty_b,
  output logic [15:0] out_duty_c,
  output logic [2:0]  out_sector,
  output logic        out_clipped,
  output logic        out_bus_fault
);

  logic                   valid_t_r, valid_s_r, valid_o_r;
  logic signed [SumW-1:0] t1_r, t2_r;
  logic signed [SumW-1:0] q1, q2;
  logic [2:0]             sector_t_r, sector_s_r;
  logic                   fault_t_r, fault_s_r;
  logic signed [SumW-1:0] a2_r, b2_r, c2_r;
  logic signed [SumW-1:0] full_s, up_s, dn_s, zero_s;
  logic signed [SumW-1:0] a2_nxt, b2_nxt, c2_nxt;
  logic [15:0]            da, db, dc;
  logic                   ca, cb, cc;
  logic [15:0]            duty_a_r, duty_b_r, duty_c_r;
  logic [2:0]             sector_o_r;
  logic                   clip_o_r, fault_o_r;

  function automatic logic [16:0] sat(input logic signed [SumW-1:0] d);
    logic [SumW-2:0] h;
    logic [16:0]     r;
    h = d[SumW-1:1];
    if (d[SumW-1]) begin
      r = {1'b1, 16'd0};
    end else if (|h[SumW-2:16]) begin
      r = {1'b1, MaxDuty};
    end else begin
      r = {1'b0, h[15:0]};
    end
    return r;
  endfunction

  assign q1 = $signed({4'd0, in_data.pq1});
  assign q2 = $signed({4'd0, in_data.pq2});

  assign full_s = t1_r + t2_r + OneQ16;
  assign up_s = t2_r - t1_r + OneQ16;
  assign dn_s = t1_r - t2_r + OneQ16;
  assign zero_s = OneQ16 - t1_r - t2_r;

  always_comb begin
    case (sector_t_r)
      Sect1: begin a2_nxt = full_s; b2_nxt = up_s; c2_nxt = zero_s; end
      Sect2: begin a2_nxt = dn_s; b2_nxt = full_s; c2_nxt = zero_s; end
      Sect3: begin a2_nxt = zero_s; b2_nxt = full_s; c2_nxt = up_s; end
      Sect4: begin a2_nxt = zero_s; b2_nxt = dn_s; c2_nxt = full_s; end
      Sect5: begin a2_nxt = up_s; b2_nxt = zero_s; c2_nxt = full_s; end
      Sect6: begin a2_nxt = full_s; b2_nxt = zero_s; c2_nxt = dn_s; end
      default: begin a2_nxt = zero_s; b2_nxt = zero_s; c2_nxt = zero_s; end
    endcase
  end

  assign {ca, da} = sat(a2_r);
  assign {cb, db} = sat(b2_r);
  assign {cc, dc} = sat(c2_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_t_r <= 1'b0;
      valid_s_r <= 1'b0;
      valid_o_r <= 1'b0;
    end else if (adv) begin
      valid_t_r <= in_valid;
      valid_s_r <= valid_t_r;
      valid_o_r <= valid_s_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t1_r <= in_data.side.neg1 ? -q1 : q1;
      t2_r <= in_data.side.neg2 ? -q2 : q2;
      sector_t_r <= in_data.side.sector;
      fault_t_r <= (in_data.vs == '0);
      a2_r <= a2_nxt;
      b2_r <= b2_nxt;
      c2_r <= c2_nxt;
      sector_s_r <= sector_t_r;
      fault_s_r <= fault_t_r;
      sector_o_r <= sector_s_r;
      fault_o_r <= fault_s_r;
      if (fault_s_r || sector_s_r == SectNull) begin
        duty_a_r <= HalfDuty;
        duty_b_r <= HalfDuty;
        duty_c_r <= HalfDuty;
        clip_o_r <= 1'b0;
      end else begin
        duty_a_r <= da;
        duty_b_r <= db;
        duty_c_r <= dc;
        clip_o_r <= ca | cb | cc;
      end
    end
  end

  assign out_valid = valid_o_r;
  assign out_duty_a = duty_a_r;
  assign out_duty_b = duty_b_r;
  assign out_duty_c = duty_c_r;
  assign out_sector = sector_o_r;
  assign out_clipped = clip_o_r;
  assign out_bus_fault = fault_o_r;

endmodule

### sv/space_vector_pwm_duty_unit.sv
// Top level of the space vector PWM duty unit.
//
//  Channel   Direction  Handshake              Payload
//  in_       input      in_valid / in_stall    voltage_a/b/c, dc_link
//  out_      output     out_valid / out_stall  duty_a/b/c, sector, clipped, bus_fault
//  cfg_      input      cfg_wr_en              cfg_wr_data (mod_index)
//
// One transfer is taken in every cycle unless the output stalls; a result is offered
// once its input transfer has passed through 52 register stages: the 47-stage restoring
// divider, one quotient bit per stage, plus two front and three back stages.
// A stalled output freezes the whole pipeline, so in_stall follows out_stall while a
// result waits. Reset clears all valid bits and sets mod_index to 1.0.
module space_vector_pwm_duty_unit
  import svpd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_voltage_a,
  input  logic [15:0] in_voltage_b,
  input  logic [15:0] in_voltage_c,
  input  logic [15:0] in_dc_link,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_duty_a,
  output logic [15:0] out_duty_b,
  output logic [15:0] out_duty_c,
  output logic [2:0]  out_sector,
  output logic        out_clipped,
  output logic        out_bus_fault,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  logic [15:0] mod_index_r;
  logic        adv;
  logic        f_valid, d_valid;
  div_t        f_data, d_data;

  assign adv = !out_valid || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_index_r <= ModIndexReset;
    end else if (cfg_wr_en) begin
      mod_index_r <= cfg_wr_data;
    end
  end

  svpd_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .adv            (adv),
    .in_valid       (in_valid),
    .in_voltage_a   (in_voltage_a),
    .in_voltage_b   (in_voltage_b),
    .in_voltage_c   (in_voltage_c),
    .in_dc_link     (in_dc_link),
    .mod_index      (mod_index_r),
    .div_valid      (f_valid),
    .div_data       (f_data)
  );

  svpd_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (f_valid),
    .in_data   (f_data),
    .out_valid (d_valid),
    .out_data  (d_data)
  );

  svpd_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .adv           (adv),
    .in_valid      (d_valid),
    .in_data       (d_data),
    .out_valid     (out_valid),
    .out_duty_a    (out_duty_a),
    .out_duty_b    (out_duty_b),
    .out_duty_c    (out_duty_c),
    .out_sector    (out_sector),
    .out_clipped   (out_clipped),
    .out_bus_fault (out_bus_fault)
  );

endmodule
